### design/pci_pkg.sv
`default_nettype none

package pci_pkg;

    // Field widths of the curve rows and of the lookup.
    localparam int SPEED_BITS = 16;
    localparam int SPEED_FRAC = 8;
    localparam int COEF_W     = 16;
    localparam int ROW_IDX_W  = 5;
    localparam int CFG_ROWS_W = 6;
    localparam int GAIN_W     = 32;
    localparam int GAIN_FRAC  = 16;
    localparam int WATTS_W    = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_ROWS_DEFAULT = 32;

    // Shared 16 x 16 multiplier; the power product is built limb by limb.
    localparam int LIMB_W      = 16;
    localparam int PROD_W      = GAIN_W + COEF_W + 3 * SPEED_BITS;
    localparam int LIMBS       = PROD_W / LIMB_W;
    localparam int WATTS_SHIFT = GAIN_FRAC + 3 * SPEED_FRAC + COEF_W;

    // Thrust coefficient outside the curve: 0.99 below it, 0.0001 above it.
    localparam logic [COEF_W-1:0] CT_BELOW = 16'd64881;
    localparam logic [COEF_W-1:0] CT_ABOVE = 16'd7;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_GAIN  = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [ROW_IDX_W-1:0]  row_index;
        logic [SPEED_BITS-1:0] row_speed;
        logic [COEF_W-1:0]     row_power_coeff;
        logic [COEF_W-1:0]     row_thrust_coeff;
        logic [SPEED_BITS-1:0] wind_speed;
    } t_in_item;

    typedef struct packed {
        logic [COEF_W-1:0]  power_coeff;
        logic [COEF_W-1:0]  thrust_coeff;
        logic [WATTS_W-1:0] power_watts;
        logic               in_range;
    } t_out_item;

    typedef struct packed {
        logic [SPEED_BITS-1:0] speed;
        logic [COEF_W-1:0]     power_coeff;
        logic [COEF_W-1:0]     thrust_coeff;
    } t_row;

    localparam int ROW_W = $bits(t_row);

endpackage

`default_nettype wire

### design/power_curve_interpolator.sv
// Turbine power curve lookup. The curve is a table of breakpoints in ascending
// wind speed, each with a power and a thrust coefficient, held in one memory.
// Input channel (i_in_valid / o_in_ready / i_in_data): a write item stores one
// row in its accept cycle, gives no result and leaves o_in_ready high. A lookup
// item makes o_in_ready fall until its result has been placed in the output
// register. Output channel (o_out_valid / i_out_ready / o_out_data): one result
// per lookup, held stable until taken. A waiting result does not block the
// next item; only a finished lookup that finds the output register still full
// waits for it. Configuration writes are taken at any cycle (o_cfg_ready is
// always high) and must only come while the block is idle.
// Outside the curve a lookup ends after reading the last and the first rows; on
// the first breakpoint it goes straight to the power product. Otherwise it
// scans the rows, one row a cycle through the memory read port, and then runs
// two 16-step restoring divisions for the two coefficients. Every lookup inside
// the curve ends with 24 steps of the shared 16 x 16 multiplier building the
// 96-bit power product.
// Reset clears the sequencer, the output valid and the configuration registers
// (2 rows in use, zero gain); the curve memory is not cleared, and rows must be
// written before a lookup reads them.
`default_nettype none

module power_curve_interpolator
    import pci_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(MAX_ROWS);
    localparam int CW    = ($clog2(MAX_ROWS + 1) > CFG_ROWS_W) ?
                           $clog2(MAX_ROWS + 1) : CFG_ROWS_W;
    localparam int DIV_CW = $clog2(COEF_W);
    localparam int LIMB_CW = $clog2(LIMBS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_FIRST,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_WATTS,
        S_FIN
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [CFG_ROWS_W-1:0] r_rows, n_rows;
    logic [GAIN_W-1:0]     r_gain, n_gain;

    // Lookup working registers.
    logic [SPEED_BITS-1:0] r_ws, n_ws;
    logic [SPEED_BITS-1:0] r_last, n_last;
    logic [AW-1:0]         r_idx, n_idx;
    logic [SPEED_BITS-1:0] r_x0, n_x0;
    logic [COEF_W-1:0]     r_p0, n_p0;
    logic [COEF_W-1:0]     r_t0, n_t0;
    logic [COEF_W-1:0]     r_p1, n_p1;
    logic [COEF_W-1:0]     r_t1, n_t1;
    logic [SPEED_BITS-1:0] r_span, n_span;
    logic [SPEED_BITS-1:0] r_off, n_off;
    logic                  r_sel, n_sel;
    logic [SPEED_BITS-1:0] r_rem, n_rem;
    logic [COEF_W-1:0]     r_dq, n_dq;
    logic [DIV_CW-1:0]     r_cnt, n_cnt;
    logic [COEF_W-1:0]     r_cp, n_cp;
    logic [COEF_W-1:0]     r_ct, n_ct;
    logic                  r_inr, n_inr;
    logic [PROD_W-1:0]     r_v, n_v;
    logic [LIMB_W-1:0]     r_carry, n_carry;
    logic [LIMB_CW-1:0]    r_limb, n_limb;
    logic [1:0]            r_pass, n_pass;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    // Memory port signals.
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [ROW_W-1:0] ram_rdata;
    t_row             rd_row;
    t_row             wr_row;

    logic              in_acc;
    logic [CW-1:0]     n_rows_used;
    logic [COEF_W-1:0] y0, y1, dy;
    logic              y_neg;
    logic [COEF_W-1:0] coef_res;

    // Shared multiplier with carry-in.
    logic [LIMB_W-1:0]   mul_a, mul_b, mul_c;
    logic [2*LIMB_W-1:0] mul_p;

    // Divider step.
    logic [SPEED_BITS:0] div_trial;
    logic                div_ge;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;

    // A row count below two acts as two, and one above the depth as the depth.
    always_comb begin
        if (r_rows < CFG_ROWS_W'(2)) begin
            n_rows_used = CW'(2);
        end else if (CW'(r_rows) > CW'(MAX_ROWS)) begin
            n_rows_used = CW'(MAX_ROWS);
        end else begin
            n_rows_used = CW'(r_rows);
        end
    end

    // Writes arrive only in the accept cycle; rows beyond the depth are dropped.
    assign wr_row.speed        = i_in_data.row_speed;
    assign wr_row.power_coeff  = i_in_data.row_power_coeff;
    assign wr_row.thrust_coeff = i_in_data.row_thrust_coeff;
    assign ram_wdata = wr_row;
    assign ram_waddr = AW'(i_in_data.row_index);
    assign ram_we    = in_acc && (i_in_data.opcode == OP_WRITE) &&
                       (32'(i_in_data.row_index) < MAX_ROWS);
    assign rd_row    = ram_rdata;

    // The read address runs one row ahead of the row being examined.
    always_comb begin
        case (r_state)
            S_IDLE:  ram_raddr = AW'(n_rows_used - CW'(1));
            S_LAST:  ram_raddr = '0;
            S_FIRST: ram_raddr = AW'(1);
            S_SCAN:  ram_raddr = r_idx + AW'(1);
            default: ram_raddr = '0;
        endcase
    end

    // Interpolation operands: power coefficient first, then thrust.
    assign y0       = r_sel ? r_t0 : r_p0;
    assign y1       = r_sel ? r_t1 : r_p1;
    assign y_neg    = (y1 < y0);
    assign dy       = y_neg ? (y0 - y1) : (y1 - y0);
    assign coef_res = y_neg ? (y0 - r_dq) : (y0 + r_dq);

    always_comb begin
        if (r_state == S_WATTS) begin
            mul_a = r_v[LIMB_W-1:0];
            mul_b = (r_pass == 2'd0) ? r_cp : r_ws;
            mul_c = r_carry;
        end else begin
            mul_a = dy;
            mul_b = r_off;
            mul_c = '0;
        end
        mul_p = (2*LIMB_W)'(mul_a) * (2*LIMB_W)'(mul_b) + (2*LIMB_W)'(mul_c);
    end

    // Restoring division: the remainder starts below the span, so the
    // quotient fits the coefficient width.
    assign div_trial = {r_rem, r_dq[COEF_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_span});

    always_comb begin
        n_state     = r_state;
        n_rows      = r_rows;
        n_gain      = r_gain;
        n_ws        = r_ws;
        n_last      = r_last;
        n_idx       = r_idx;
        n_x0        = r_x0;
        n_p0        = r_p0;
        n_t0        = r_t0;
        n_p1        = r_p1;
        n_t1        = r_t1;
        n_span      = r_span;
        n_off       = r_off;
        n_sel       = r_sel;
        n_rem       = r_rem;
        n_dq        = r_dq;
        n_cnt       = r_cnt;
        n_cp        = r_cp;
        n_ct        = r_ct;
        n_inr       = r_inr;
        n_v         = r_v;
        n_carry     = r_carry;
        n_limb      = r_limb;
        n_pass      = r_pass;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS_IN_USE: n_rows = i_cfg_data[CFG_ROWS_W-1:0];
                CFG_POWER_GAIN:  n_gain = i_cfg_data[GAIN_W-1:0];
                default:         n_rows = r_rows;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.opcode == OP_LOOKUP)) begin
                    n_ws    = i_in_data.wind_speed;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_last  = rd_row.speed;
                n_state = S_FIRST;
            end
            S_FIRST: begin
                n_x0 = rd_row.speed;
                n_p0 = rd_row.power_coeff;
                n_t0 = rd_row.thrust_coeff;
                n_v  = '0;
                if (r_ws < rd_row.speed) begin
                    n_cp    = '0;
                    n_ct    = CT_BELOW;
                    n_inr   = 1'b0;
                    n_state = S_FIN;
                end else if (r_ws > r_last) begin
                    n_cp    = '0;
                    n_ct    = CT_ABOVE;
                    n_inr   = 1'b0;
                    n_state = S_FIN;
                end else if (rd_row.speed >= r_ws) begin
                    // Exactly on the first breakpoint.
                    n_cp    = rd_row.power_coeff;
                    n_ct    = rd_row.thrust_coeff;
                    n_inr   = 1'b1;
                    n_v     = PROD_W'(r_gain);
                    n_carry = '0;
                    n_limb  = '0;
                    n_pass  = '0;
                    n_state = S_WATTS;
                end else begin
                    n_inr   = 1'b1;
                    n_idx   = AW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_row.speed >= r_ws) begin
                    n_span  = rd_row.speed - r_x0;
                    n_off   = r_ws - r_x0;
                    n_p1    = rd_row.power_coeff;
                    n_t1    = rd_row.thrust_coeff;
                    n_sel   = 1'b0;
                    n_state = S_MUL;
                end else begin
                    n_x0  = rd_row.speed;
                    n_p0  = rd_row.power_coeff;
                    n_t0  = rd_row.thrust_coeff;
                    n_idx = r_idx + AW'(1);
                end
            end
            S_MUL: begin
                n_rem   = mul_p[COEF_W +: SPEED_BITS];
                n_dq    = mul_p[COEF_W-1:0];
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = div_ge ? SPEED_BITS'(div_trial - {1'b0, r_span})
                               : div_trial[SPEED_BITS-1:0];
                n_dq  = {r_dq[COEF_W-2:0], div_ge};
                n_cnt = r_cnt + DIV_CW'(1);
                if (r_cnt == DIV_CW'(COEF_W - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!r_sel) begin
                    n_cp    = coef_res;
                    n_sel   = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_ct    = coef_res;
                    n_v     = PROD_W'(r_gain);
                    n_carry = '0;
                    n_limb  = '0;
                    n_pass  = '0;
                    n_state = S_WATTS;
                end
            end
            S_WATTS: begin
                // One limb a cycle: the vector rotates so the low limb is
                // always the one being multiplied.
                n_v     = {mul_p[LIMB_W-1:0], r_v[PROD_W-1:LIMB_W]};
                n_carry = mul_p[2*LIMB_W-1:LIMB_W];
                n_limb  = r_limb + LIMB_CW'(1);
                if (r_limb == LIMB_CW'(LIMBS - 1)) begin
                    n_limb  = '0;
                    n_carry = '0;
                    n_pass  = r_pass + 2'd1;
                    if (r_pass == 2'd3) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.power_coeff  = r_cp;
                    n_out.thrust_coeff = r_ct;
                    n_out.power_watts  = r_v[WATTS_SHIFT +: WATTS_W];
                    n_out.in_range     = r_inr;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rows      <= CFG_ROWS_W'(2);
            r_gain      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rows      <= n_rows;
            r_gain      <= n_gain;
            r_ws        <= n_ws;
            r_last      <= n_last;
            r_idx       <= n_idx;
            r_x0        <= n_x0;
            r_p0        <= n_p0;
            r_t0        <= n_t0;
            r_p1        <= n_p1;
            r_t1        <= n_t1;
            r_span      <= n_span;
            r_off       <= n_off;
            r_sel       <= n_sel;
            r_rem       <= n_rem;
            r_dq        <= n_dq;
            r_cnt       <= n_cnt;
            r_cp        <= n_cp;
            r_ct        <= n_ct;
            r_inr       <= n_inr;
            r_v         <= n_v;
            r_carry     <= n_carry;
            r_limb      <= n_limb;
            r_pass      <= n_pass;
            r_out       <= n_out;
        end
    end

    pci_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ROWS)
    ) u_curve_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### design/pci_ram.sv
`default_nettype none

module pci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/pci_checker.sv
`default_nettype none

module pci_checker
    import pci_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A lookup occupies the block from the next cycle on.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.opcode == OP_LOOKUP) |=> !o_in_ready)
        else $error("ready stayed high after a lookup");

    // A row write completes in its accept cycle.
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.opcode == OP_WRITE) |=> o_in_ready)
        else $error("ready fell after a row write");

    // Outside the curve there is no power and a fixed thrust coefficient for each side.
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.in_range |->
            (o_out_data.power_coeff == '0) && (o_out_data.power_watts == '0) &&
            ((o_out_data.thrust_coeff == CT_BELOW) ||
             (o_out_data.thrust_coeff == CT_ABOVE)))
        else $error("bad result outside the curve");

endmodule

bind power_curve_interpolator pci_checker u_pci_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
